// ----- rtl/sshm_pkg.sv -----
package sshm_pkg;

    typedef logic [7:0] t_byte;

    localparam int STOP_REGS = 4;
    localparam int REG_IDX_W = 3;
    localparam int STOP_IDX_W = 2;

    localparam logic OP_FEED  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STOP_LENGTHS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STOP_TEXT0   = 3'd2;

    localparam logic [15:0] STOP_LENGTHS_RST = 16'h1111;

endpackage

// ----- rtl/sshm_in_if.sv -----
interface sshm_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] chunk_bytes;
    logic [3:0]  chunk_length;

    modport source (output valid, operation, chunk_bytes, chunk_length, input ready);
    modport sink   (input valid, operation, chunk_bytes, chunk_length, output ready);
endinterface

// ----- rtl/sshm_out_if.sv -----
interface sshm_out_if;
    logic                             valid;
    logic                             ready;
    sshm_pkg::t_byte                  out_byte;
    logic                             byte_valid;
    logic                             matched;
    logic [sshm_pkg::STOP_IDX_W-1:0]  match_index;
    logic                             last;

    modport source (output valid, out_byte, byte_valid, matched, match_index, last,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, matched, match_index, last,
                    output ready);
endinterface

// ----- rtl/sshm_cfg_if.sv -----
interface sshm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sshm_pkg::REG_IDX_W-1:0]   reg_index;
    logic [63:0]                      wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/stop_string_holdback_matcher.sv -----
// Channel   Dir  Payload                                            Handshake
// i_in      in   operation, chunk_bytes, chunk_length               valid/ready
// o_out     out  out_byte, byte_valid, matched, match_index, last   valid/ready
// i_cfg     in   reg_index, wdata                                   valid/ready
//
// One item: a load, then a scan over n window positions (n = held bytes + chunk bytes,
// one window position per cycle through the shared window comparator, ending early on
// a full match), then the emitted results. Flush, empty and pass-through items skip
// the scan.
// Reset is synchronous, active low; it clears the held tail and the spent flag.
// Input ready drops for the whole item; output stalls only pause emission.
module stop_string_holdback_matcher #(
    parameter int NUM_STOPS    = 4,
    parameter int MAX_STOP_LEN = 8,
    parameter int CHUNK_BYTES  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sshm_in_if.sink     i_in,
    sshm_out_if.source  o_out,
    sshm_cfg_if.sink    i_cfg
);

    localparam int TAIL_DEPTH = MAX_STOP_LEN - 1;
    localparam int BUF_LEN    = TAIL_DEPTH + CHUNK_BYTES;
    localparam int CW         = $clog2(BUF_LEN + 1);
    localparam int TCW        = $clog2(TAIL_DEPTH + 1);
    localparam int NREG       = (NUM_STOPS < sshm_pkg::STOP_REGS) ? NUM_STOPS
                                                                  : sshm_pkg::STOP_REGS;
    localparam int SW         = sshm_pkg::STOP_IDX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // configuration
    logic [2:0]   r_stop_count;
    logic [15:0]  r_stop_lengths;
    logic [63:0]  r_stop_text [NREG];

    // control
    logic [1:0]     r_state;
    logic [CW-1:0]  r_n;
    logic [CW-1:0]  r_rem;
    logic [CW-1:0]  r_emit_left;
    logic [TCW-1:0] r_tail_count;
    logic [TCW-1:0] r_hold;
    logic           r_hold_found;
    logic           r_spent;
    logic           r_hit;
    logic           r_tail_upd;
    logic           r_ov;

    // data
    sshm_pkg::t_byte r_tail [TAIL_DEPTH];
    sshm_pkg::t_byte r_buf  [BUF_LEN];
    sshm_pkg::t_byte r_win  [BUF_LEN];
    logic [SW-1:0]   r_hit_idx;
    sshm_pkg::t_byte r_out_byte;
    logic            r_out_bv;
    logic            r_out_matched;
    logic [SW-1:0]   r_out_idx;
    logic            r_out_last;

    // combinational
    logic [2:0]      w_nst;
    logic [CW-1:0]   w_len [NREG];
    logic [3:0]      w_clen4;
    logic [CW-1:0]   w_clen;
    logic [CW-1:0]   w_n;
    sshm_pkg::t_byte w_load  [BUF_LEN];
    sshm_pkg::t_byte w_pass  [BUF_LEN];
    sshm_pkg::t_byte w_flush [BUF_LEN];
    sshm_pkg::t_byte w_sh    [BUF_LEN];
    sshm_pkg::t_byte w_win_sh[BUF_LEN];
    logic            w_full_any;
    logic [SW-1:0]   w_full_idx;
    logic            w_part_any;
    logic [TCW-1:0]  w_hold_final;
    logic            w_in_fire;
    logic            w_emit_go;
    logic            w_emit_last;
    logic            w_bypass;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_emit_go   = (r_state == S_EMIT) && (!r_ov || o_out.ready);
    assign w_emit_last = (r_emit_left <= CW'(1));

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.byte_valid  = r_out_bv;
    assign o_out.matched     = r_out_matched;
    assign o_out.match_index = r_out_idx;
    assign o_out.last        = r_out_last;

    assign w_nst    = (r_stop_count > 3'(NREG)) ? 3'(NREG) : r_stop_count;
    assign w_bypass = r_spent || (w_nst == 3'd0);
    assign w_clen4  = (i_in.chunk_length > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES)
                                                            : i_in.chunk_length;
    assign w_clen   = CW'(w_clen4);
    assign w_n      = CW'(r_tail_count) + w_clen;

    always_comb begin
        logic [3:0] nib;
        for (int k = 0; k < NREG; k++) begin
            nib = r_stop_lengths[4*k +: 4];
            if (nib == 4'd0) begin
                nib = 4'd1;
            end else if (nib > 4'(MAX_STOP_LEN)) begin
                nib = 4'(MAX_STOP_LEN);
            end
            w_len[k] = CW'(nib);
        end
    end

    // buffer loads
    always_comb begin
        for (int i = 0; i < BUF_LEN; i++) begin
            w_load[i]  = '0;
            w_pass[i]  = '0;
            w_flush[i] = '0;
            if (i < CHUNK_BYTES) begin
                w_pass[i] = i_in.chunk_bytes[8*i +: 8];
            end
            if (i < TAIL_DEPTH) begin
                w_flush[i] = r_tail[i];
            end
            for (int t = 0; t <= TAIL_DEPTH; t++) begin
                if (r_tail_count == TCW'(t)) begin
                    if (i < t) begin
                        w_load[i] = r_tail[i];
                    end else if (i - t < CHUNK_BYTES) begin
                        w_load[i] = i_in.chunk_bytes[8*(i-t) +: 8];
                    end
                end
            end
            w_sh[i]     = (i + 1 < BUF_LEN) ? r_buf[i+1] : '0;
            w_win_sh[i] = (i + 1 < BUF_LEN) ? r_win[i+1] : '0;
        end
    end

    // shared window comparator: all stops against the window at the current position
    always_comb begin
        logic eq;
        w_full_any = 1'b0;
        w_full_idx = '0;
        w_part_any = 1'b0;
        for (int k = 0; k < NREG; k++) begin
            eq = (3'(k) < w_nst);
            for (int j = 0; j < MAX_STOP_LEN; j++) begin
                if ((CW'(j) < w_len[k]) && (CW'(j) < r_rem)
                        && (r_win[j] != r_stop_text[k][8*j +: 8])) begin
                    eq = 1'b0;
                end
            end
            if (eq && (w_len[k] <= r_rem)) begin
                if (!w_full_any) begin
                    w_full_idx = SW'(k);
                end
                w_full_any = 1'b1;
            end
            if (eq && (w_len[k] > r_rem)) begin
                w_part_any = 1'b1;
            end
        end
    end

    assign w_hold_final = r_hold_found ? r_hold : (w_part_any ? TCW'(1) : '0);

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count   <= '0;
            r_stop_lengths <= sshm_pkg::STOP_LENGTHS_RST;
            for (int k = 0; k < NREG; k++) begin
                r_stop_text[k] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                sshm_pkg::REG_STOP_COUNT: begin
                    r_stop_count <= i_cfg.wdata[2:0];
                end
                sshm_pkg::REG_STOP_LENGTHS: begin
                    r_stop_lengths <= i_cfg.wdata[15:0];
                end
                default: begin
                    for (int k = 0; k < NREG; k++) begin
                        if (i_cfg.reg_index == sshm_pkg::REG_STOP_TEXT0 + 3'(k)) begin
                            r_stop_text[k] <= i_cfg.wdata;
                        end
                    end
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_n          <= '0;
            r_rem        <= '0;
            r_emit_left  <= '0;
            r_tail_count <= '0;
            r_hold       <= '0;
            r_hold_found <= 1'b0;
            r_spent      <= 1'b0;
            r_hit        <= 1'b0;
            r_tail_upd   <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (w_emit_go) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_hit        <= 1'b0;
                        r_tail_upd   <= 1'b0;
                        r_hold       <= '0;
                        r_hold_found <= 1'b0;
                        r_n          <= w_n;
                        r_rem        <= w_n;
                        if (i_in.operation == sshm_pkg::OP_FLUSH) begin
                            r_emit_left  <= CW'(r_tail_count);
                            r_tail_count <= '0;
                            r_state      <= S_EMIT;
                        end else if (w_bypass) begin
                            r_emit_left <= w_clen;
                            r_state     <= S_EMIT;
                        end else if (w_n == '0) begin
                            r_emit_left <= '0;
                            r_state     <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_full_any) begin
                        r_hit        <= 1'b1;
                        r_emit_left  <= r_n - r_rem;
                        r_tail_count <= '0;
                        r_spent      <= 1'b1;
                        r_state      <= S_EMIT;
                    end else begin
                        if (!r_hold_found && w_part_any) begin
                            r_hold_found <= 1'b1;
                            r_hold       <= TCW'(r_rem);
                        end
                        if (r_rem == CW'(1)) begin
                            r_emit_left  <= r_n - CW'(w_hold_final);
                            r_tail_count <= w_hold_final;
                            r_tail_upd   <= 1'b1;
                            r_state      <= S_EMIT;
                        end else begin
                            r_rem <= r_rem - CW'(1);
                        end
                    end
                end
                S_EMIT: begin
                    if (w_emit_go) begin
                        if (w_emit_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_emit_left <= r_emit_left - CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            for (int i = 0; i < BUF_LEN; i++) begin
                if (i_in.operation == sshm_pkg::OP_FLUSH) begin
                    r_buf[i] <= w_flush[i];
                end else if (w_bypass) begin
                    r_buf[i] <= w_pass[i];
                end else begin
                    r_buf[i] <= w_load[i];
                end
                r_win[i] <= w_load[i];
            end
        end
        if (r_state == S_SCAN) begin
            for (int i = 0; i < BUF_LEN; i++) begin
                r_win[i] <= w_win_sh[i];
            end
            if (w_full_any) begin
                r_hit_idx <= w_full_idx;
            end
        end
        if (w_emit_go) begin
            r_out_bv      <= (r_emit_left != '0);
            r_out_byte    <= (r_emit_left != '0) ? r_buf[0] : '0;
            r_out_last    <= w_emit_last;
            r_out_matched <= w_emit_last && r_hit;
            r_out_idx     <= (w_emit_last && r_hit) ? r_hit_idx : '0;
            if (r_emit_left != '0) begin
                for (int i = 0; i < BUF_LEN; i++) begin
                    r_buf[i] <= w_sh[i];
                end
            end
            // held tail sits at the front of the buffer once the rest is out
            if (w_emit_last && r_tail_upd) begin
                for (int i = 0; i < TAIL_DEPTH; i++) begin
                    r_tail[i] <= (r_emit_left == '0) ? r_buf[i] : w_sh[i];
                end
            end
        end
    end

endmodule

// ----- bench/tb_stop_string_holdback_matcher.sv -----
`timescale 1ns / 1ps

module tb_stop_string_holdback_matcher;

    typedef struct packed {
        sshm_pkg::t_byte out_byte;
        logic            byte_valid;
        logic            matched;
        logic [1:0]      match_index;
        logic            last;
    } t_result;

    // fixed = 1: expected results typed in the row instead of predicted
    typedef struct packed {
        logic        op;
        logic [63:0] data;
        logic [3:0]  len;
        logic        fixed;
        logic [63:0] exp_bytes;
        logic [3:0]  exp_n;
        logic        exp_hit;
        logic [1:0]  exp_idx;
    } t_row;

    localparam logic OP_FEED  = sshm_pkg::OP_FEED;
    localparam logic OP_FLUSH = sshm_pkg::OP_FLUSH;

    localparam int ROW_STOPS_ON  = 5;
    localparam int ROW_STOPS_OFF = 18;

    logic i_clk;
    logic i_rst_n;

    sshm_in_if  in_ch();
    sshm_out_if out_ch();
    sshm_cfg_if cfg_ch();

    stop_string_holdback_matcher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // matcher state as the block should hold it
    logic [2:0]      cfg_count;
    logic [15:0]     cfg_lens;
    logic [63:0]     cfg_text [sshm_pkg::STOP_REGS];
    sshm_pkg::t_byte held [7];
    int              held_n;
    bit              spent_q;

    t_result item_results [$];
    t_result due_results [$];
    int      errors;
    int      items_sent;
    int      src_pct;
    int      snk_pct;
    int      walk_k;
    int      walk_j;

    t_row dir_rows [20] = '{
        '{OP_FEED,  64'h0,                 4'd0,  1'b1, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 2'd0},
        '{OP_FEED,  64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 2'd0},
        '{OP_FLUSH, 64'h0,                 4'd0,  1'b1, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h0,                 4'd8,  1'b1, 64'h0,                 4'd8, 1'b0, 2'd0},
        '{OP_FEED,  64'hA5A5_A5A5_A54E_4571, 4'd3, 1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FLUSH, 64'h0,                 4'd0,  1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h0047_4645_4443_4241, 4'd7, 1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h7A,                4'd1,  1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h0047_4645_4443_4241, 4'd7, 1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h0,                 4'd0,  1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h7A7A_7A7A_7A7A_7A7A, 4'd8, 1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h7863_6261,         4'd4,  1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h7A,                4'd1,  1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h4567_6665_6463_6261, 4'd9, 1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h4E,                4'd1,  1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FLUSH, 64'h0,                 4'd0,  1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h43_4241,           4'd3,  1'b0, 64'h0,                 4'd0, 1'b0, 2'd0},
        '{OP_FEED,  64'h44_4E45,           4'd3,  1'b1, 64'h44_4E45,           4'd3, 1'b0, 2'd0},
        '{OP_FLUSH, 64'h0,                 4'd0,  1'b0, 64'h0,                 4'd0, 1'b0, 2'd0}
    };

    function automatic int stop_len_of(input int k);
        int l;
        l = int'(cfg_lens[4*k +: 4]);
        if (l < 1) l = 1;
        if (l > 8) l = 8;
        return l;
    endfunction

    function automatic void emit_bytes(input sshm_pkg::t_byte b [15], input int n,
                                       input bit hit, input int idx);
        t_result r;
        if (n == 0) begin
            r = '0;
            r.matched = hit;
            r.match_index = hit ? 2'(idx) : 2'd0;
            r.last = 1'b1;
            item_results.push_back(r);
        end
        for (int i = 0; i < n; i++) begin
            r = '0;
            r.out_byte = b[i];
            r.byte_valid = 1'b1;
            r.last = (i == n - 1);
            r.matched = r.last && hit;
            r.match_index = (r.last && hit) ? 2'(idx) : 2'd0;
            item_results.push_back(r);
        end
    endfunction

    // fills item_results; commit = 0 leaves the state alone. Returns 1 on a match.
    function automatic bit scan_and_emit(input logic op, input logic [63:0] data,
                                         input logic [3:0] len, input bit commit);
        sshm_pkg::t_byte win [15];
        int clen, nst, n, hold, first_at, best_k, l, m;
        bit ok;
        clen = (len > 4'd8) ? 8 : int'(len);
        nst = (cfg_count > 3'd4) ? 4 : int'(cfg_count);
        item_results.delete();
        for (int i = 0; i < 15; i++) win[i] = '0;
        if (op == OP_FLUSH) begin
            for (int i = 0; i < held_n; i++) win[i] = held[i];
            emit_bytes(win, held_n, 1'b0, 0);
            if (commit) held_n = 0;
            return 1'b0;
        end
        if (spent_q || nst == 0) begin
            for (int i = 0; i < clen; i++) win[i] = data[8*i +: 8];
            emit_bytes(win, clen, 1'b0, 0);
            return 1'b0;
        end
        for (int i = 0; i < held_n; i++) win[i] = held[i];
        for (int i = 0; i < clen; i++) win[held_n + i] = data[8*i +: 8];
        n = held_n + clen;

        first_at = 15;
        best_k = 0;
        for (int k = 0; k < nst; k++) begin
            l = stop_len_of(k);
            for (int p = 0; p + l <= n && p < first_at; p++) begin
                ok = 1'b1;
                for (int j = 0; j < l; j++)
                    if (win[p + j] != cfg_text[k][8*j +: 8]) ok = 1'b0;
                if (ok) begin
                    first_at = p;
                    best_k = k;
                    break;
                end
            end
        end
        if (first_at < 15) begin
            emit_bytes(win, first_at, 1'b1, best_k);
            if (commit) begin
                held_n = 0;
                spent_q = 1'b1;
            end
            return 1'b1;
        end

        hold = 0;
        for (int k = 0; k < nst; k++) begin
            l = stop_len_of(k);
            m = (l - 1 > n) ? n : l - 1;
            for (int s = m; s >= 1 && s > hold; s--) begin
                ok = 1'b1;
                for (int j = 0; j < s; j++)
                    if (win[n - s + j] != cfg_text[k][8*j +: 8]) ok = 1'b0;
                if (ok) begin
                    hold = s;
                    break;
                end
            end
        end
        if (hold > 7) hold = 7;
        emit_bytes(win, n - hold, 1'b0, 0);
        if (commit) begin
            for (int i = 0; i < hold; i++) held[i] = win[n - hold + i];
            held_n = hold;
        end
        return 1'b0;
    endfunction

    // mostly walks partway along a stop string so prefixes straddle items
    function automatic sshm_pkg::t_byte gen_byte();
        int r, k;
        sshm_pkg::t_byte b;
        r = $urandom_range(99);
        if (r < 65 && stop_len_of(walk_k) > 1) begin
            b = cfg_text[walk_k][8*walk_j +: 8];
            walk_j++;
            if (walk_j >= stop_len_of(walk_k) - 1 || $urandom_range(9) == 0) begin
                walk_k = $urandom_range(sshm_pkg::STOP_REGS - 1);
                walk_j = 0;
            end
        end else if (r < 85) begin
            walk_k = $urandom_range(sshm_pkg::STOP_REGS - 1);
            walk_j = 0;
            k = $urandom_range(sshm_pkg::STOP_REGS - 1);
            b = cfg_text[k][8*$urandom_range(stop_len_of(k) - 1) +: 8];
        end else begin
            b = sshm_pkg::t_byte'($urandom);
        end
        return b;
    endfunction

    function automatic logic [63:0] rand_text(input sshm_pkg::t_byte base, input int span);
        logic [63:0] t;
        for (int j = 0; j < 8; j++)
            t[8*j +: 8] = base + sshm_pkg::t_byte'($urandom_range(span - 1));
        return t;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic push_item(input t_row it);
        sshm_pkg::t_byte typed [15];
        src_pct = (items_sent < 105) ? 25 : (items_sent < 210) ? 50 : 0;
        snk_pct = (items_sent < 105) ? 50 : (items_sent < 210) ? 25 : 0;
        while ($urandom_range(99) < src_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.operation = it.op;
        in_ch.chunk_bytes = it.data;
        in_ch.chunk_length = it.len;
        do @(posedge i_clk); while (!in_ch.ready);
        void'(scan_and_emit(it.op, it.data, it.len, 1'b1));
        if (it.fixed) begin
            item_results.delete();
            for (int i = 0; i < 15; i++) typed[i] = (i < 8) ? it.exp_bytes[8*i +: 8] : '0;
            emit_bytes(typed, int'(it.exp_n), it.exp_hit, int'(it.exp_idx));
        end
        foreach (item_results[i]) due_results.push_back(item_results[i]);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        in_ch.valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sshm_pkg::REG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wdata = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == sshm_pkg::REG_STOP_COUNT) cfg_count = val[2:0];
        else if (idx == sshm_pkg::REG_STOP_LENGTHS) cfg_lens = val[15:0];
        else cfg_text[idx - sshm_pkg::REG_STOP_TEXT0] = val;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic load_stops(input logic [2:0] cnt, input logic [15:0] lens,
                              input logic [63:0] t0, input logic [63:0] t1,
                              input logic [63:0] t2, input logic [63:0] t3);
        wait_drain();
        write_reg(sshm_pkg::REG_STOP_COUNT, {32'($urandom), 29'($urandom), cnt});
        write_reg(sshm_pkg::REG_STOP_LENGTHS, {32'($urandom), 16'($urandom), lens});
        write_reg(sshm_pkg::REG_STOP_TEXT0, t0);
        write_reg(sshm_pkg::REG_STOP_TEXT0 + 3'd1, t1);
        write_reg(sshm_pkg::REG_STOP_TEXT0 + 3'd2, t2);
        write_reg(sshm_pkg::REG_STOP_TEXT0 + 3'd3, t3);
    endtask

    // random items; those that would match are redrawn, then replaced by a flush
    task automatic run_random(input int count);
        t_row it;
        int tries, r;
        bit clash;
        for (int n = 0; n < count; n++) begin
            tries = 0;
            do begin
                it = '0;
                it.data = {$urandom, $urandom};
                r = $urandom_range(99);
                it.len = (r < 5) ? 4'd0 : (r < 12) ? 4'($urandom_range(15, 9))
                                                   : 4'($urandom_range(8, 1));
                for (int i = 0; i < 8 && i < int'(it.len); i++) it.data[8*i +: 8] = gen_byte();
                it.op = ($urandom_range(99) < 10) ? OP_FLUSH : OP_FEED;
                clash = scan_and_emit(it.op, it.data, it.len, 1'b0);
                tries++;
            end while (clash && tries < 8);
            if (clash) it.op = OP_FLUSH;
            if ($urandom_range(49) == 0) wait_drain();
            push_item(it);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) out_ch.ready = ($urandom_range(99) >= snk_pct);

    always @(posedge i_clk) begin : check_out
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing actual byte %0h last %0b",
                         $time, out_ch.out_byte, out_ch.last);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("out_byte", want.out_byte, out_ch.out_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(out_ch.byte_valid));
                check_field("matched", 8'(want.matched), 8'(out_ch.matched));
                check_field("match_index", 8'(want.match_index), 8'(out_ch.match_index));
                check_field("last", 8'(want.last), 8'(out_ch.last));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb_stop_string_holdback_matcher: errors");
        $finish;
    end

    initial begin
        errors = 0;
        items_sent = 0;
        src_pct = 0;
        snk_pct = 0;
        walk_k = 0;
        walk_j = 0;
        cfg_count = '0;
        cfg_lens = sshm_pkg::STOP_LENGTHS_RST;
        for (int k = 0; k < sshm_pkg::STOP_REGS; k++) cfg_text[k] = '0;
        held_n = 0;
        spent_q = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_FEED;
        in_ch.chunk_bytes = '0;
        in_ch.chunk_length = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = sshm_pkg::REG_STOP_COUNT;
        cfg_ch.wdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // stops: "END", "xy", '#' (zero length nibble), "ABCDEFGH" (nibble F); count 7
        for (int r = 0; r < 20; r++) begin
            if (r == ROW_STOPS_ON)
                load_stops(3'd7, 16'hF023, 64'h44_4E45, 64'h7978, 64'h23,
                           64'h4847_4645_4443_4241);
            if (r == ROW_STOPS_OFF) begin
                wait_drain();
                write_reg(sshm_pkg::REG_STOP_COUNT, 64'h0);
            end
            push_item(dir_rows[r]);
        end

        load_stops(3'd4, 16'h8536, rand_text(8'h61, 4), rand_text(8'h61, 4),
                   rand_text(8'h61, 4), rand_text(8'h61, 4));
        run_random(70);
        load_stops(3'd1, 16'hFFFF, '1, rand_text(8'h41, 8), rand_text(8'h61, 8),
                   {$urandom, $urandom});
        run_random(60);
        load_stops(3'd0, 16'h0000, 64'h0, 64'h0, 64'h0, 64'h0);
        run_random(30);
        load_stops(3'd7, 16'h0F0F, rand_text(8'h41, 3), 64'h0, rand_text(8'h41, 3), '1);
        run_random(60);

        // "QR", "PQ", "PQRS": PQ and PQRS start together, lower index wins
        load_stops(3'd4, 16'h8422, {32'($urandom), 16'($urandom), 16'h5251},
                   {32'($urandom), 16'($urandom), 16'h5150},
                   {32'($urandom), 32'h5352_5150}, rand_text(8'h61, 4));
        push_item('{OP_FLUSH, 64'h0, 4'd0, 1'b0, 64'h0, 4'd0, 1'b0, 2'd0});
        push_item('{OP_FEED, 64'h53_5251_506D, 4'd5, 1'b0, 64'h0, 4'd0, 1'b0, 2'd0});
        run_random(70);

        wait_drain();
        repeat (40) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb_stop_string_holdback_matcher: clean");
        end else begin
            $display("tb_stop_string_holdback_matcher: errors");
        end
        $finish;
    end

endmodule
